// ===== hw/rtl/gsca_pkg.sv =====
package gsca_pkg;

  localparam int SLOTS           = 256;
  localparam int SPECIAL_ENTRIES = 288;

  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TBL_AW  = (SPECIAL_ENTRIES > 1) ? $clog2(SPECIAL_ENTRIES) : 1;
  localparam int MAX_N   = (SLOTS > SPECIAL_ENTRIES) ? SLOTS : SPECIAL_ENTRIES;
  localparam int CNT_W   = $clog2(MAX_N + 1);

  localparam int SLOT_DW = 24;
  localparam int TBL_DW  = 16;

  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_GLYPH = 2'd1;
  localparam logic [1:0] ST_BUSY     = 2'd2;

  localparam logic [15:0] CODE_SPLIT  = 16'h883f;
  localparam logic [15:0] CODE_OFFSET = 16'h861f;
  localparam logic [14:0] TBL_BASE    = 15'd256;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [7:0]  FULL_LEAD   = 8'h81;
  localparam logic [7:0]  FULL_TRAIL  = 8'h40;
  localparam logic [4:0]  W_SPACE     = 5'd24;
  localparam logic [4:0]  W_FULL      = 5'd13;
  localparam logic [7:0]  THR_RESET   = 8'd3;
  localparam logic [7:0]  AGE_MAX     = 8'hff;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LATCH,
    CMD_CLR,
    CMD_TSCAN,
    CMD_SSCAN,
    CMD_TICK,
    CMD_FIN
  } cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       out_free;
    logic [1:0] in_mode;
    logic       in_need_tscan;
  } dp_stat_t;

endpackage

// ===== hw/rtl/gsca_ram.sv =====
module gsca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/gsca_ctrl.sv =====
module gsca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gsca_pkg::dp_stat_t stat,
  output gsca_pkg::cmd_t    cmd
);
  import gsca_pkg::*;

  typedef enum logic [5:0] {
    S_CLR   = 6'b000001,
    S_IDLE  = 6'b000010,
    S_TSCAN = 6'b000100,
    S_SSCAN = 6'b001000,
    S_TICK  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_IDLE;
    case (state_r)
      S_CLR: begin
        cmd = CMD_CLR;
        if (stat.scan_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd = CMD_LATCH;
          if (stat.in_mode == MODE_REQ) begin
            state_nxt = stat.in_need_tscan ? S_TSCAN : S_SSCAN;
          end else if (stat.in_mode == MODE_TICK) begin
            state_nxt = S_TICK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_TSCAN: begin
        cmd = CMD_TSCAN;
        if (stat.scan_done) state_nxt = S_SSCAN;
      end
      S_SSCAN: begin
        cmd = CMD_SSCAN;
        if (stat.scan_done) state_nxt = S_FIN;
      end
      S_TICK: begin
        cmd = CMD_TICK;
        if (stat.scan_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd       = CMD_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/gsca_dp.sv =====
module gsca_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  gsca_pkg::cmd_t     cmd,
  output gsca_pkg::dp_stat_t stat,
  input  logic [1:0]         in_tuser,
  input  logic [31:0]        in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);
  import gsca_pkg::*;

  logic [7:0]         thr_r;
  logic [1:0]         mode_r;
  logic [7:0]         lead_r, trail_r;
  logic [8:0]         tidx_r;
  logic               need_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               pv_r;
  logic               t_hit_r, m_hit_r, f_hit_r, e_hit_r;
  logic [TBL_AW-1:0]  t_idx_r;
  logic [SLOT_AW-1:0] m_idx_r, f_idx_r, e_idx_r;
  logic [SLOTS-1:0]   used_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic [7:0]         in_lead, in_trail;
  logic [CNT_W-1:0]   limit, cnt_m1;
  logic               done, dbl, ok, used_e, tidx_ok;
  logic [SLOT_AW-1:0] e_s, new_slot;
  logic [15:0]        code;
  logic [14:0]        rec;
  logic [4:0]         pin_w;
  logic [7:0]         age;

  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_waddr;
  logic [TBL_DW-1:0]  tbl_wdata, tbl_rdata;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SLOT_DW-1:0] slot_wdata, slot_rdata;
  logic [31:0]        res;

  assign in_lead  = in_tdata[7:0];
  assign in_trail = in_tdata[15:8];

  assign limit  = (cmd == CMD_CLR || cmd == CMD_TSCAN) ? CNT_W'(SPECIAL_ENTRIES) : CNT_W'(SLOTS);
  assign done   = (cnt_r == limit);
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign e_s    = cnt_m1[SLOT_AW-1:0];
  assign used_e = used_r[e_s];
  assign age    = slot_rdata[7:0];

  assign dbl     = lead_r[7];
  assign code    = {lead_r, trail_r};
  assign ok      = !need_r || t_hit_r;
  assign tidx_ok = ({1'b0, tidx_r} < 10'(SPECIAL_ENTRIES));
  assign rec     = need_r ? (TBL_BASE + 15'(t_idx_r))
                 : (dbl ? 15'(code - CODE_OFFSET) : 15'(lead_r));
  assign pin_w   = (lead_r == CH_SPACE) ? W_SPACE
                 : ((lead_r == FULL_LEAD && trail_r == FULL_TRAIL) ? W_FULL : 5'd0);
  assign new_slot = f_hit_r ? f_idx_r : e_idx_r;

  assign stat.scan_done     = done;
  assign stat.out_free      = !out_valid_r || out_tready;
  assign stat.in_mode       = in_tuser;
  assign stat.in_need_tscan = in_lead[7] && ({in_lead, in_trail} < CODE_SPLIT);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = cnt_r[TBL_AW-1:0];
    tbl_wdata = '0;
    if (cmd == CMD_CLR && !done) begin
      tbl_we = 1'b1;
    end else if (cmd == CMD_FIN && mode_r == MODE_LOAD && tidx_ok) begin
      tbl_we    = 1'b1;
      tbl_waddr = tidx_r[TBL_AW-1:0];
      tbl_wdata = {lead_r, trail_r};
    end
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = e_s;
    slot_wdata = {slot_rdata[23:8], age + 8'd1};
    if (cmd == CMD_TICK && pv_r && used_e && age != AGE_MAX) begin
      slot_we = 1'b1;
    end else if (cmd == CMD_FIN && mode_r == MODE_REQ && ok) begin
      slot_wdata = {lead_r, (dbl ? trail_r : 8'd0), 8'd0};
      if (m_hit_r) begin
        slot_we    = 1'b1;
        slot_waddr = m_idx_r;
      end else if (f_hit_r || e_hit_r) begin
        slot_we    = 1'b1;
        slot_waddr = new_slot;
      end
    end
  end

  always_comb begin
    res = '0;
    if (mode_r == MODE_REQ) begin
      if (!ok) begin
        res[1:0] = ST_NO_GLYPH;
      end else if (m_hit_r) begin
        res[9:2]   = 8'(m_idx_r);
        res[24:10] = rec;
      end else if (f_hit_r || e_hit_r) begin
        res[9:2]   = 8'(new_slot);
        res[24:10] = rec;
        res[25]    = 1'b1;
        res[26]    = !f_hit_r;
        res[31:27] = pin_w;
      end else begin
        res[1:0] = ST_BUSY;
      end
    end
  end

  gsca_ram #(.WIDTH(TBL_DW), .DEPTH(SPECIAL_ENTRIES), .AW(TBL_AW)) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (cnt_r[TBL_AW-1:0]),
    .rd_data (tbl_rdata)
  );

  gsca_ram #(.WIDTH(SLOT_DW), .DEPTH(SLOTS), .AW(SLOT_AW)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (cnt_r[SLOT_AW-1:0]),
    .rd_data (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (cmd == CMD_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_LATCH: begin
          cnt_r <= '0;
          pv_r  <= 1'b0;
        end
        CMD_CLR: begin
          if (!done) cnt_r <= cnt_r + CNT_W'(1);
        end
        CMD_TSCAN, CMD_SSCAN, CMD_TICK: begin
          if (done) begin
            cnt_r <= '0;
            pv_r  <= 1'b0;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
            pv_r  <= 1'b1;
          end
        end
        CMD_FIN: begin
          if (mode_r == MODE_REQ && ok && !m_hit_r && (f_hit_r || e_hit_r)) begin
            used_r[new_slot] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LATCH: begin
        mode_r  <= in_tuser;
        lead_r  <= in_lead;
        trail_r <= in_trail;
        tidx_r  <= in_tdata[24:16];
        need_r  <= stat.in_need_tscan;
        t_hit_r <= 1'b0;
        m_hit_r <= 1'b0;
        f_hit_r <= 1'b0;
        e_hit_r <= 1'b0;
      end
      CMD_TSCAN: begin
        if (pv_r && !t_hit_r && tbl_rdata == code) begin
          t_hit_r <= 1'b1;
          t_idx_r <= cnt_m1[TBL_AW-1:0];
        end
      end
      CMD_SSCAN: begin
        if (pv_r) begin
          if (!m_hit_r && used_e && slot_rdata[23:16] == lead_r &&
              (!dbl || slot_rdata[15:8] == trail_r)) begin
            m_hit_r <= 1'b1;
            m_idx_r <= e_s;
          end
          if (!f_hit_r && !used_e) begin
            f_hit_r <= 1'b1;
            f_idx_r <= e_s;
          end
          if (!e_hit_r && used_e && age > thr_r) begin
            e_hit_r <= 1'b1;
            e_idx_r <= e_s;
          end
        end
      end
      CMD_FIN: out_data_r <= res;
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/glyph_slot_cache_allocator.sv =====
// A glyph request scans the table RAM and then the slot RAM for a
// table-mapped code and only the slot RAM otherwise; an age tick scans the slot RAM.
// A table load or an unused mode needs no scan; one item is in work at a time,
// so the next input transfer is taken only once the last result is registered.
// The scans of the table and slot RAMs read one entry per cycle.
// Reset is synchronous; afterwards the table is cleared, and during the clear
// no input transfer is taken.
module glyph_slot_cache_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  input  logic [31:0] in_tdata,   // lead_byte, trail_byte, table_index, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status, slot_index, glyph record, is_new, evicted,
                                  // pinned_width
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import gsca_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  gsca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gsca_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

// ===== hw/rtl/gsca_checker.sv =====
module gsca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import gsca_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= ST_BUSY)
    else $error("undefined status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[31:2] == 30'd0)
    else $error("failed result carries data");

  a_old_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[25] |-> !out_tdata[26] && out_tdata[31:27] == 5'd0)
    else $error("eviction or width on a reused slot");

  a_clear: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input taken during table clear");

endmodule

bind glyph_slot_cache_allocator gsca_checker u_gsca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/tb_glyph_slot_cache_allocator.sv =====
module tb_glyph_slot_cache_allocator;
  import gsca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [4:0]  pinned_width;
    logic        evicted;
    logic        is_new;
    logic [14:0] glyph_rec;
    logic [7:0]  slot_index;
    logic [1:0]  status;
  } glyph_result_t;

  class glyph_cache_board;
    bit            used [SLOTS];
    logic [7:0]    lead_q [SLOTS];
    logic [7:0]    trail_q [SLOTS];
    logic [7:0]    age [SLOTS];
    logic [15:0]   special_q [SPECIAL_ENTRIES];
    logic [7:0]    threshold;
    glyph_result_t awaited_q [$];
    int            errors, results, hits, fresh, evictions, busy, missing;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        used[i] = 0; lead_q[i] = '0; trail_q[i] = '0; age[i] = '0;
      end
      for (int i = 0; i < SPECIAL_ENTRIES; i++) special_q[i] = '0;
      threshold = THR_RESET;
    endfunction

    function void note_input(logic [1:0] mode, logic [7:0] lead, logic [7:0] trail,
                             logic [8:0] idx);
      glyph_result_t r;
      logic [15:0] code, rec;
      bit dbl, mapped, done;
      int slot;
      r = '0;
      code = {lead, trail};
      dbl = lead[7];
      rec = '0;
      mapped = 1;
      done = 0;
      slot = -1;
      if (mode == MODE_TICK) begin
        for (int i = 0; i < SLOTS; i++) if (age[i] != AGE_MAX) age[i] = age[i] + 8'd1;
      end else if (mode == MODE_LOAD) begin
        if (idx < SPECIAL_ENTRIES) special_q[idx] = code;
      end else if (mode == MODE_REQ) begin
        if (!dbl) rec = {8'd0, lead};
        else if (code < CODE_SPLIT) begin
          mapped = 0;
          for (int i = 0; i < SPECIAL_ENTRIES && !mapped; i++)
            if (special_q[i] == code) begin
              mapped = 1;
              rec = 16'(TBL_BASE) + 16'(i);
            end
        end else rec = code - CODE_OFFSET;
        if (!mapped) r.status = ST_NO_GLYPH;
        else begin
          for (int i = 0; i < SLOTS && !done; i++)
            if (used[i] && lead_q[i] == lead && (!dbl || trail_q[i] == trail)) begin
              done = 1;
              age[i] = '0;
              r.slot_index = i[7:0];
              r.glyph_rec = rec[14:0];
            end
          if (!done) begin
            for (int i = 0; i < SLOTS && slot < 0; i++) if (!used[i]) slot = i;
            for (int i = 0; i < SLOTS && slot < 0; i++)
              if (age[i] > threshold) begin
                slot = i;
                r.evicted = 1;
              end
            if (slot < 0) r.status = ST_BUSY;
            else begin
              r.pinned_width = (lead == CH_SPACE) ? W_SPACE :
                               (lead == FULL_LEAD && trail == FULL_TRAIL) ? W_FULL : 5'd0;
              used[slot] = 1;
              lead_q[slot] = lead;
              trail_q[slot] = dbl ? trail : 8'd0;
              age[slot] = '0;
              r.slot_index = slot[7:0];
              r.glyph_rec = rec[14:0];
              r.is_new = 1;
            end
          end
        end
      end
      awaited_q.push_back(r);
    endfunction

    function void mismatch(string field, int exp_v, int act_v);
      if (errors < MAX_REPORTS)
        $display("result %0d: %s expected %0d, got %0d", results, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(logic [31:0] data);
      glyph_result_t a, e;
      a = data;
      results++;
      if (awaited_q.size() == 0) begin
        if (errors < MAX_REPORTS) $display("result %0d arrived with none awaited", results);
        errors++;
      end else begin
        e = awaited_q.pop_front();
        if (a.status !== e.status) mismatch("status", e.status, a.status);
        if (a.slot_index !== e.slot_index) mismatch("slot_index", e.slot_index, a.slot_index);
        if (a.glyph_rec !== e.glyph_rec) mismatch("glyph_rec", e.glyph_rec, a.glyph_rec);
        if (a.is_new !== e.is_new) mismatch("is_new", e.is_new, a.is_new);
        if (a.evicted !== e.evicted) mismatch("evicted", e.evicted, a.evicted);
        if (a.pinned_width !== e.pinned_width)
          mismatch("pinned_width", e.pinned_width, a.pinned_width);
        if (e.status == ST_BUSY) busy++;
        if (e.status == ST_NO_GLYPH) missing++;
        if (e.evicted) evictions++;
        if (e.is_new) fresh++;
        else if (e.status == ST_OK && e.glyph_rec != 0) hits++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 0;
  logic [7:0]  cfg_wr_data = '0;

  glyph_cache_board board = new();
  bit   calm = 0;
  int   cycles = 0;
  int   stall = 0;
  logic [15:0] loaded_codes [$];
  logic [15:0] asked_codes [$];

  glyph_slot_cache_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_glyph_slot_cache_allocator: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (stall > 0) begin
      stall <= stall - 1;
      out_tready <= 0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall <= pick_gap();
      out_tready <= 0;
    end else out_tready <= 1;
  end

  task automatic send(logic [1:0] mode, logic [7:0] lead, logic [7:0] trail, logic [8:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {7'd0, idx, trail, lead};
    do @(posedge clk); while (!in_tready);
    board.note_input(mode, lead, trail, idx);
    if (mode == MODE_REQ) asked_codes.push_back({lead, trail});
    if (mode == MODE_LOAD) loaded_codes.push_back({lead, trail});
  endtask

  task automatic settle();
    in_tvalid <= 0;
    while (board.awaited_q.size() != 0) @(posedge clk);
    repeat (SPECIAL_ENTRIES + SLOTS + 10) @(posedge clk);
  endtask

  task automatic set_threshold(logic [7:0] v);
    settle();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.threshold = v;
  endtask

  task automatic random_item();
    int r;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 12) send(MODE_TICK, 8'($urandom), 8'($urandom), 9'($urandom));
    else if (r < 20) begin
      c = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h8000, 16'h883e));
      send(MODE_LOAD, c[15:8], c[7:0], 9'($urandom_range(0, 511)));
    end else if (r < 22) send(MODE_SPARE, 8'($urandom), 8'($urandom), 9'($urandom));
    else begin
      r = $urandom_range(0, 99);
      if (r < 35 && asked_codes.size() > 0)
        c = asked_codes[$urandom_range(0, asked_codes.size() - 1)];
      else if (r < 55 && loaded_codes.size() > 0)
        c = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
      else if (r < 70) c = {1'b0, 7'($urandom), 8'($urandom)};
      else if (r < 80) c = 16'($urandom_range(16'h8000, 16'h883e));
      else c = 16'($urandom);
      if (asked_codes.size() > 64) void'(asked_codes.pop_front());
      send(MODE_REQ, c[15:8], c[7:0], 9'($urandom));
    end
  endtask

  initial begin
    board.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1;

    send(MODE_LOAD, FULL_LEAD, FULL_TRAIL, 9'd0);
    send(MODE_LOAD, 8'h88, 8'h3e, 9'd287);
    send(MODE_LOAD, 8'h81, 8'h41, 9'd288);
    send(MODE_LOAD, 8'h81, 8'h42, 9'd511);
    send(MODE_LOAD, 8'h81, 8'h40, 9'd5);
    send(MODE_REQ, CH_SPACE, 8'hff, 9'd0);
    send(MODE_REQ, FULL_LEAD, FULL_TRAIL, 9'd0);
    send(MODE_REQ, 8'h00, 8'h00, 9'd0);
    send(MODE_REQ, 8'h7f, 8'h12, 9'd0);
    send(MODE_REQ, 8'h7f, 8'h34, 9'h1ff);
    send(MODE_REQ, 8'h88, 8'h3e, 9'd0);
    send(MODE_REQ, 8'h88, 8'h3f, 9'd0);
    send(MODE_REQ, 8'hff, 8'hff, 9'd0);
    send(MODE_REQ, 8'h80, 8'h00, 9'd0);
    send(MODE_REQ, 8'h81, 8'h41, 9'd0);
    send(MODE_REQ, 8'h81, 8'h42, 9'd0);
    send(MODE_SPARE, 8'hff, 8'hff, 9'h1ff);
    for (int i = 0; i < 5; i++) send(MODE_TICK, 8'h00, 8'h00, 9'd0);
    send(MODE_REQ, CH_SPACE, 8'h00, 9'd0);
    send(MODE_REQ, 8'h90, 8'h00, 9'd0);

    set_threshold(8'd255);
    calm = 1;
    for (int i = 0; i < 90; i++) send(MODE_TICK, 8'h00, 8'h00, 9'd0);
    calm = 0;
    for (int i = 0; i < 70; i++) send(MODE_TICK, 8'h00, 8'h00, 9'd0);
    for (int i = 0; i < 260; i++) send(MODE_REQ, 8'h90 + 8'(i >> 8), 8'(i), 9'd0);
    send(MODE_REQ, 8'hff, 8'hfe, 9'd0);

    set_threshold(8'd0);
    send(MODE_TICK, 8'h00, 8'h00, 9'd0);
    send(MODE_REQ, 8'h20, 8'h00, 9'd0);
    send(MODE_REQ, 8'hfe, 8'h01, 9'd0);

    for (int p = 0; p < 4; p++) begin
      set_threshold((p == 3) ? 8'd255 : 8'($urandom_range(0, 6)));
      for (int i = 0; i < 75; i++) begin
        if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        random_item();
      end
      calm = 0;
    end

    settle();
    $display("%0d results: %0d new, %0d hits, %0d evictions, %0d busy, %0d no-glyph",
             board.results, board.fresh, board.hits, board.evictions, board.busy,
             board.missing);
    $display("covered table loads, ticks, single and double-byte codes, full cache");
    if (board.errors == 0 && board.awaited_q.size() == 0)
      $display("tb_glyph_slot_cache_allocator: PASS");
    else begin
      $display("%0d mismatches, %0d results outstanding", board.errors,
               board.awaited_q.size());
      $display("tb_glyph_slot_cache_allocator: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/gsca_pkg.sv
hw/rtl/gsca_ram.sv
hw/rtl/gsca_ctrl.sv
hw/rtl/gsca_dp.sv
hw/rtl/glyph_slot_cache_allocator.sv
hw/rtl/gsca_checker.sv
dv/tb_glyph_slot_cache_allocator.sv
